// ----- hdl/range_polynomial_hash_tree_macros.svh -----
// Assertion macros shared by the hash tree RTL.
`ifndef RANGE_POLYNOMIAL_HASH_TREE_MACROS_SVH
`define RANGE_POLYNOMIAL_HASH_TREE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RPH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RPH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/rph_pkg.sv -----
// Shared types and constants for the hash tree.
package rph_pkg;
  localparam int unsigned WordW = 63;
  localparam logic [WordW-1:0] ModulusReset = 63'd4000000000000000037;
  localparam logic [WordW-1:0] BaseReset = 63'd666667;
  localparam logic CfgModulus = 1'b0;
  localparam logic CfgBase = 1'b1;
  typedef logic [WordW-1:0] word_t;
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
    word_t m;
  } mul_req_t;
endpackage

// ----- hdl/range_polynomial_hash_tree.sv -----
// Top level: segment tree of polynomial hash terms with a shared multiplier.
// Update of a leaf: one multiply pass on value[62:0], a second pass when value bit 63
// is set, then a read of both children and a sum per tree level up to the root.
// Query: both range ends read per tree level walked, then one multiply pass; empty query
// answers the cycle after acceptance. One item at a time: busy is high until the item ends.
// Reset and every cfg write clear all 2*LEAVES tree entries, then compute LEAVES powers.
`include "range_polynomial_hash_tree_macros.svh"
module range_polynomial_hash_tree import rph_pkg::*; #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [9:0]  in_first_index,
  input  logic [9:0]  in_last_index,
  input  logic [63:0] in_value,
  output logic        out_valid,
  output logic [62:0] out_hash,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [62:0] cfg_data
);
  localparam int unsigned LW = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int unsigned NW = LW + 1;
  localparam int unsigned PW = $clog2(LEAVES + 1);

  typedef enum logic [3:0] {
    S_CLR, S_PWR, S_PWAIT, S_IDLE, S_UMUL, S_UWAIT, S_URD, S_UADD,
    S_QRD, S_QADD, S_QSTEP, S_QMUL, S_QWAIT
  } state_t;

  state_t state_r;
  word_t mod_r, base_r, m_eff;
  word_t tree_mem [2*LEAVES];
  word_t pwr_mem [LEAVES+1];
  logic [NW:0] clr_r;
  logic [PW:0] pi_r;
  logic [NW-1:0] p_r, l_r, r_r;
  logic [NW-1:0] rd_addr;
  word_t rd_data, pw_data, prev_r, sum_r, lft_r;
  logic [PW-1:0] pw_addr;
  logic [63:0] val_r;
  logic phase_r;
  mul_req_t mreq;
  logic mdone;
  word_t mprod;

  assign m_eff = (mod_r < 63'd2) ? 63'd2 : mod_r;
  assign busy = (state_r != S_IDLE);

  function automatic word_t addm(input word_t a, input word_t b, input word_t m);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    addm = (s >= {1'b0, m}) ? WordW'(s - {1'b0, m}) : WordW'(s);
  endfunction

  rph_mulmod u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .done(mdone), .product(mprod));

  always_ff @(posedge clk) begin
    rd_data <= tree_mem[rd_addr];
    pw_data <= pwr_mem[pw_addr];
  end

  always_comb begin
    rd_addr = p_r;
    if (state_r == S_QRD) rd_addr = phase_r ? r_r : l_r;
    else if (state_r == S_URD) rd_addr = {p_r[NW-2:0], phase_r};
    pw_addr = PW'(pi_r);
    if (state_r == S_IDLE) pw_addr = in_mode ? PW'(LEAVES - in_first_index)
                                             : PW'(in_first_index);
  end

  // The value is up to 64 bits but the multiplier's b operand is 63; the high bit is folded
  // by sending value[62:0] and adding pw*2^62 twice from a second pass when needed.
  logic hi_pend_r;
  word_t part_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      mod_r <= ModulusReset;
      base_r <= BaseReset;
      clr_r <= '0;
      pi_r <= '0;
      out_valid <= 1'b0;
      mreq.start <= 1'b0;
      hi_pend_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      mreq.start <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CfgModulus) mod_r <= cfg_data;
        else base_r <= cfg_data;
        state_r <= S_CLR;
        clr_r <= '0;
        pi_r <= '0;
      end else begin
        unique case (state_r)
          S_CLR: begin
            tree_mem[clr_r[NW-1:0]] <= '0;
            clr_r <= clr_r + 1'b1;
            if (clr_r == (NW+1)'(2*LEAVES - 1)) begin
              pwr_mem[0] <= (m_eff == 63'd1) ? '0 : 63'd1;
              prev_r <= 63'd1;
              pi_r <= (PW+1)'(1);
              state_r <= S_PWR;
            end
          end
          S_PWR: begin
            mreq.start <= 1'b1;
            mreq.a <= prev_r;
            mreq.b <= base_r;
            mreq.m <= m_eff;
            state_r <= S_PWAIT;
          end
          S_PWAIT: if (mdone) begin
            pwr_mem[pi_r[PW-1:0]] <= mprod;
            prev_r <= mprod;
            if (pi_r == (PW+1)'(LEAVES)) begin
              state_r <= S_IDLE;
            end else begin
              pi_r <= pi_r + 1'b1;
              state_r <= S_PWR;
            end
          end
          S_IDLE: if (start) begin
            // The power index is latched here so the power read stays on it.
            pi_r <= (PW+1)'(in_mode ? PW'(LEAVES - in_first_index) : PW'(in_first_index));
            val_r <= in_value;
            if (!in_mode) begin
              if (32'(in_first_index) < LEAVES) begin
                p_r <= NW'(LEAVES + 32'(in_first_index));
                state_r <= S_UMUL;
              end
            end else begin
              logic [9:0] hi;
              hi = (32'(in_last_index) >= LEAVES) ? 10'(LEAVES - 1) : in_last_index;
              if (in_first_index > hi) begin
                out_valid <= 1'b1;
                out_hash <= '0;
              end else begin
                l_r <= NW'(LEAVES + 32'(in_first_index));
                r_r <= NW'(LEAVES + 32'(hi));
                sum_r <= '0;
                phase_r <= 1'b0;
                state_r <= S_QRD;
              end
            end
          end
          S_UMUL: begin
            // value = hi*2^63 + low; leaf = pw*low + (pw*2^62)*2 computed in two passes.
            mreq.start <= 1'b1;
            mreq.a <= pw_data;
            mreq.b <= val_r[62:0];
            mreq.m <= m_eff;
            hi_pend_r <= val_r[63];
            part_r <= '0;
            state_r <= S_UWAIT;
          end
          S_UWAIT: if (mdone) begin
            if (hi_pend_r) begin
              hi_pend_r <= 1'b0;
              part_r <= mprod;
              mreq.start <= 1'b1;
              mreq.a <= pw_data;
              mreq.b <= 63'h4000000000000000;
              mreq.m <= m_eff;
              val_r[63] <= 1'b1;
              val_r[62] <= 1'b1;
            end else begin
              logic [WordW-1:0] leaf;
              leaf = addm(part_r, mprod, m_eff);
              if (val_r[62] && val_r[63]) leaf = addm(leaf, mprod, m_eff);
              tree_mem[p_r] <= leaf;
              p_r <= p_r >> 1;
              phase_r <= 1'b0;
              state_r <= (p_r >> 1) == '0 ? S_IDLE : S_URD;
            end
          end
          S_URD: begin
            phase_r <= ~phase_r;
            if (phase_r) state_r <= S_UADD;
            lft_r <= rd_data;
          end
          S_UADD: begin
            tree_mem[p_r] <= addm(lft_r, rd_data, m_eff);
            p_r <= p_r >> 1;
            phase_r <= 1'b0;
            state_r <= (p_r >> 1) == '0 ? S_IDLE : S_URD;
          end
          S_QRD: begin
            state_r <= S_QADD;
          end
          S_QADD: begin
            if (!phase_r) begin
              if (l_r[0]) sum_r <= addm(sum_r, rd_data, m_eff);
              phase_r <= 1'b1;
              state_r <= S_QRD;
            end else begin
              if (!r_r[0]) sum_r <= addm(sum_r, rd_data, m_eff);
              phase_r <= 1'b0;
              state_r <= S_QSTEP;
            end
          end
          S_QSTEP: begin
            logic [NW:0] nl, nr;
            nl = ({1'b0, l_r} + 1'b1) >> 1;
            nr = ({1'b0, r_r} - 1'b1) >> 1;
            l_r <= NW'(nl);
            r_r <= NW'(nr);
            state_r <= (nl <= nr) ? S_QRD : S_QMUL;
          end
          S_QMUL: begin
            mreq.start <= 1'b1;
            mreq.a <= sum_r;
            mreq.b <= pw_data;
            mreq.m <= m_eff;
            state_r <= S_QWAIT;
          end
          S_QWAIT: if (mdone) begin
            out_valid <= 1'b1;
            out_hash <= mprod;
            state_r <= S_IDLE;
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  `RPH_ASSERT_IMP(a_no_result_busy_cfg, clk, rst_n, out_valid, !(state_r == S_CLR))
  `RPH_ASSERT_NXT(a_start_leaves_idle, clk, rst_n,
                  state_r == S_IDLE && start && !in_mode && !cfg_we, state_r == S_UMUL)
  `RPH_ASSERT_IMP(a_sum_below_mod, clk, rst_n, state_r == S_QMUL, sum_r < m_eff)
endmodule

// ----- hdl/rph_mulmod.sv -----
// Bit-serial modular multiplier: one bit of the multiplier per cycle.
`include "range_polynomial_hash_tree_macros.svh"
module rph_mulmod import rph_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output logic     done,
  output word_t    product
);
  word_t a_r, a_nxt, acc_r, acc_nxt, m_r;
  logic [WordW:0] b_r, b_nxt;
  logic busy_r;
  logic [WordW:0] sum_acc, dbl;

  // Operand a is reduced here: a may be up to 2^63-1 while m is smaller.
  function automatic word_t red(input word_t x, input word_t m);
    logic [WordW:0] t;
    t = {1'b0, x};
    // x < 2^63 and m >= 2, but x may exceed 2m; the caller guarantees x < 2m.
    red = (t >= {1'b0, m}) ? WordW'(t - {1'b0, m}) : x;
  endfunction

  always_comb begin
    sum_acc = {1'b0, acc_r} + {1'b0, a_r};
    if (sum_acc >= {1'b0, m_r}) sum_acc = sum_acc - {1'b0, m_r};
    dbl = {a_r, 1'b0};
    if (dbl >= {1'b0, m_r}) dbl = dbl - {1'b0, m_r};
    acc_nxt = b_r[0] ? WordW'(sum_acc) : acc_r;
    a_nxt = WordW'(dbl);
    b_nxt = b_r >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        a_r <= red(req.a, req.m);
        b_r <= {1'b0, req.b};
        acc_r <= '0;
        m_r <= req.m;
      end else if (busy_r) begin
        if (b_r == '0) begin
          busy_r <= 1'b0;
          done <= 1'b1;
          product <= acc_r;
        end else begin
          a_r <= a_nxt;
          b_r <= b_nxt;
          acc_r <= acc_nxt;
        end
      end
    end
  end

  `RPH_ASSERT_NXT(a_done_after_busy, clk, rst_n, done, !busy_r)
  `RPH_ASSERT_IMP(a_acc_below_m, clk, rst_n, busy_r && !req.start, acc_r < m_r)
  `RPH_ASSERT_IMP(a_a_below_m, clk, rst_n, busy_r && !req.start, a_r < m_r)
endmodule
